>>> src/triangle_vertex_transform_assert.svh
// Assertion macros shared by the checker.
`ifndef TRIANGLE_VERTEX_TRANSFORM_ASSERT_SVH
`define TRIANGLE_VERTEX_TRANSFORM_ASSERT_SVH

// same-cycle implication
`define TVT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TVT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/tvt_pkg.sv
`timescale 1ns / 1ps
package tvt_pkg;

	localparam int DIV_N    = 48;          // quotient bits, one per divider stage
	localparam int LANE_LAT = DIV_N + 5;   // registers from input to lane result

	typedef logic [3:0][63:0] mat_t;

	typedef enum logic [2:0] {
		REG_ROW0   = 3'd0,
		REG_ROW1   = 3'd1,
		REG_ROW2   = 3'd2,
		REG_ROW3   = 3'd3,
		REG_NEAR   = 3'd4,
		REG_HALF_W = 3'd5,
		REG_HALF_H = 3'd6
	} reg_idx_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sh0000_0000_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sh0000_0000_8000_0000)
			return 32'sh8000_0000;
		else
			return v[31:0];
	endfunction

endpackage

>>> src/tvt_div.sv
`timescale 1ns / 1ps
// Pipelined unsigned restoring divider, one quotient bit per stage.
module tvt_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tvt_pkg::DIV_N-1:0]     dividend,
	input  logic [31:0]                   divisor,
	input  logic                          neg,
	output logic [tvt_pkg::DIV_N-1:0]     quo,
	output logic                          quo_neg
);
	localparam int N = tvt_pkg::DIV_N;

	logic [31:0]  rem_q [N+1];
	logic [N-1:0] dq_q  [N+1];
	logic [31:0]  d_q   [N+1];
	logic         neg_q [N+1];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= '0;
			dq_q[0]  <= dividend;
			d_q[0]   <= divisor;
			neg_q[0] <= neg;
		end
	end

	for (genvar k = 0; k < N; k++) begin : g_step
		logic [32:0] t;
		logic        ge;
		always_comb begin
			t  = {rem_q[k], dq_q[k][N-1]};
			ge = (t >= {1'b0, d_q[k]});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k+1] <= ge ? 32'(t - {1'b0, d_q[k]}) : t[31:0];
				dq_q[k+1]  <= {dq_q[k][N-2:0], ge};
				d_q[k+1]   <= d_q[k];
				neg_q[k+1] <= neg_q[k];
			end
		end
	end

	assign quo     = dq_q[N];
	assign quo_neg = neg_q[N];
endmodule

>>> src/tvt_lane.sv
`timescale 1ns / 1ps
// One vertex: transform, near test, divide, viewport.
module tvt_lane (
	input  logic                clk,
	input  logic                en,
	input  logic signed [31:0]  x,
	input  logic signed [31:0]  y,
	input  logic signed [31:0]  z,
	input  tvt_pkg::mat_t       mat,
	input  logic signed [31:0]  near_limit,
	input  logic [12:0]         half_w,
	input  logic [12:0]         half_h,
	output logic signed [31:0]  sx,
	output logic signed [31:0]  sy,
	output logic                keep
);
	localparam int N  = tvt_pkg::DIV_N;
	localparam int KD = tvt_pkg::LANE_LAT - 2;

	logic signed [31:0] crd [3];
	logic signed [47:0] prod_s1 [4][3];
	logic signed [15:0] c3_s1 [4];
	logic signed [49:0] acc [4];
	logic signed [31:0] t_s2 [4];
	logic               keep_q [KD];

	assign crd[0] = x;
	assign crd[1] = y;
	assign crd[2] = z;

	// s1: 12 products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 3; c++)
					prod_s1[r][c] <= 48'(signed'(mat[r][16*c +: 16])) * 48'(crd[c]);
				c3_s1[r] <= signed'(mat[r][63:48]);
			end
		end
	end

	// s2: row sums, floor to Q16.16, saturate
	always_comb begin
		for (int r = 0; r < 4; r++)
			acc[r] = 50'(prod_s1[r][0]) + 50'(prod_s1[r][1]) + 50'(prod_s1[r][2])
				+ (50'(c3_s1[r]) <<< 16);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++)
				t_s2[r] <= tvt_pkg::sat32(64'(acc[r] >>> 12));
		end
	end

	// divider set-up; zero w divides x and y by one
	logic [31:0]  xmag, ymag, wmag, dvs;
	logic         wzero;
	logic [N-1:0] dvd_x, dvd_y;
	logic         neg_x, neg_y;

	always_comb begin
		xmag  = t_s2[0][31] ? 32'(~t_s2[0] + 32'd1) : t_s2[0];
		ymag  = t_s2[1][31] ? 32'(~t_s2[1] + 32'd1) : t_s2[1];
		wmag  = t_s2[3][31] ? 32'(~t_s2[3] + 32'd1) : t_s2[3];
		wzero = (t_s2[3] == 32'sd0);
		dvs   = wzero ? 32'd1 : wmag;
		dvd_x = wzero ? {16'b0, xmag} : {xmag, 16'b0};
		dvd_y = wzero ? {16'b0, ymag} : {ymag, 16'b0};
		neg_x = wzero ? t_s2[0][31] : (t_s2[0][31] ^ t_s2[3][31]);
		neg_y = wzero ? t_s2[1][31] : (t_s2[1][31] ^ t_s2[3][31]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_q[0] <= (t_s2[2] >= near_limit);
			for (int k = 1; k < KD; k++)
				keep_q[k] <= keep_q[k-1];
		end
	end

	logic [N-1:0] qx, qy;
	logic         qx_neg, qy_neg;

	tvt_div u_div_x (
		.clk(clk), .en(en), .dividend(dvd_x), .divisor(dvs), .neg(neg_x),
		.quo(qx), .quo_neg(qx_neg)
	);
	tvt_div u_div_y (
		.clk(clk), .en(en), .dividend(dvd_y), .divisor(dvs), .neg(neg_y),
		.quo(qy), .quo_neg(qy_neg)
	);

	// viewport: (ndc + 1.0) * half
	logic signed [N:0]   ndc_x, ndc_y;
	logic signed [N+1:0] vx_s1, vy_s1;
	logic signed [63:0]  px_s2, py_s2;

	always_comb begin
		ndc_x = qx_neg ? -signed'({1'b0, qx}) : signed'({1'b0, qx});
		ndc_y = qy_neg ? -signed'({1'b0, qy}) : signed'({1'b0, qy});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vx_s1 <= (N+2)'(ndc_x) + (N+2)'(65536);
			vy_s1 <= (N+2)'(ndc_y) + (N+2)'(65536);
			px_s2 <= 64'(vx_s1) * 64'(signed'({1'b0, half_w}));
			py_s2 <= 64'(vy_s1) * 64'(signed'({1'b0, half_h}));
		end
	end

	assign sx   = tvt_pkg::sat32(px_s2);
	assign sy   = tvt_pkg::sat32(py_s2);
	assign keep = keep_q[KD-1];
endmodule

>>> src/triangle_vertex_transform.sv
`timescale 1ns / 1ps
// Triangle vertex transform: takes one triangle (three Q16.16 vertices) per
// cycle, multiplies each by the configured 4x4 Q4.12 matrix (w = 1), drops the
// triangle if any transformed z is below near_limit, divides x and y by w
// (undivided when w is zero) and maps them to the screen, saturated to Q16.16.
// Throughput is one triangle per clock while the output side is not stalled;
// the input-to-output path is set mainly by the 48-stage pipelined divider in
// each of the three vertex lanes. Dropped triangles produce no output request.
// Configuration writes are always accepted and take effect on the next cycle;
// write only while the block holds no triangle in flight.
module triangle_vertex_transform (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by_coord,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] cx,
	input  logic signed [31:0] cy,
	input  logic signed [31:0] cz,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] screen_ax,
	output logic signed [31:0] screen_ay,
	output logic signed [31:0] screen_bx,
	output logic signed [31:0] screen_by,
	output logic signed [31:0] screen_cx,
	output logic signed [31:0] screen_cy,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);
	localparam int LAT = tvt_pkg::LANE_LAT;

	// configuration registers
	tvt_pkg::mat_t      mat_q;
	logic signed [31:0] near_q;
	logic [12:0]        half_w_q, half_h_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= 64'd4096;
			mat_q[1] <= 64'd268435456;
			mat_q[2] <= 64'd17592186044416;
			mat_q[3] <= 64'd1152921504606846976;
			near_q   <= '0;
			half_w_q <= 13'd320;
			half_h_q <= 13'd240;
		end else if (cfg_valid) begin
			case (tvt_pkg::reg_idx_t'(cfg_index))
				tvt_pkg::REG_ROW0:   mat_q[0] <= cfg_data;
				tvt_pkg::REG_ROW1:   mat_q[1] <= cfg_data;
				tvt_pkg::REG_ROW2:   mat_q[2] <= cfg_data;
				tvt_pkg::REG_ROW3:   mat_q[3] <= cfg_data;
				tvt_pkg::REG_NEAR:   near_q   <= signed'(cfg_data[31:0]);
				tvt_pkg::REG_HALF_W: half_w_q <= cfg_data[12:0];
				tvt_pkg::REG_HALF_H: half_h_q <= cfg_data[12:0];
				default: ;
			endcase
		end
	end

	// the whole pipe moves together; it stalls only when a kept triangle
	// reaches the end while the output register is full and not being taken
	logic vld_q [LAT];
	logic last_vld, keep_all, adv, load;
	logic signed [31:0] sx [3];
	logic signed [31:0] sy [3];
	logic               kp [3];

	assign last_vld = vld_q[LAT-1];
	assign keep_all = kp[0] & kp[1] & kp[2];
	assign adv      = !(out_valid && !out_ready && last_vld && keep_all);
	assign load     = adv && last_vld && keep_all;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < LAT; k++)
				vld_q[k] <= 1'b0;
		end else if (adv) begin
			vld_q[0] <= in_valid;
			for (int k = 1; k < LAT; k++)
				vld_q[k] <= vld_q[k-1];
		end
	end

	// three vertex lanes
	tvt_lane u_lane_a (
		.clk(clk), .en(adv), .x(ax), .y(ay), .z(az), .mat(mat_q),
		.near_limit(near_q), .half_w(half_w_q), .half_h(half_h_q),
		.sx(sx[0]), .sy(sy[0]), .keep(kp[0])
	);
	tvt_lane u_lane_b (
		.clk(clk), .en(adv), .x(bx), .y(by_coord), .z(bz), .mat(mat_q),
		.near_limit(near_q), .half_w(half_w_q), .half_h(half_h_q),
		.sx(sx[1]), .sy(sy[1]), .keep(kp[1])
	);
	tvt_lane u_lane_c (
		.clk(clk), .en(adv), .x(cx), .y(cy), .z(cz), .mat(mat_q),
		.near_limit(near_q), .half_w(half_w_q), .half_h(half_h_q),
		.sx(sx[2]), .sy(sy[2]), .keep(kp[2])
	);

	// merge: output register
	logic               out_valid_q;
	logic signed [31:0] sax_q, say_q, sbx_q, sby_q, scx_q, scy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sax_q <= sx[0];
			say_q <= sy[0];
			sbx_q <= sx[1];
			sby_q <= sy[1];
			scx_q <= sx[2];
			scy_q <= sy[2];
		end
	end

	assign out_valid = out_valid_q;
	assign screen_ax = sax_q;
	assign screen_ay = say_q;
	assign screen_bx = sbx_q;
	assign screen_by = sby_q;
	assign screen_cx = scx_q;
	assign screen_cy = scy_q;
endmodule

>>> src/tvt_check.sv
`timescale 1ns / 1ps
`include "triangle_vertex_transform_assert.svh"
// Port-level checks.
module tvt_check (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic signed [31:0] screen_ax
);
	`TVT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(screen_ax), "output request dropped or changed while stalled")
	`TVT_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready, "input stalled while output side free")
	`TVT_ASSERT_NOW(a_cfg_take, cfg_valid, cfg_ready, "config write not taken")
endmodule

bind triangle_vertex_transform tvt_check u_check (.*);
